@@ src/dba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dba_pkg
// Shared types and constants for the disk block allocator.
// ----------------------------------------------------------------------------
package dba_pkg;

    localparam int BLOCK_COUNT_DEF = 1024;
    localparam int MAX_FILES_DEF   = 255;
    localparam int MAX_LENGTH_DEF  = 64;

    localparam int BLK_IDX_W = 10;
    localparam int LEN_W     = 7;
    localparam int FID_W     = 8;
    localparam int STAT_W    = 2;
    localparam int CFG_W     = 11;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_TAKEN = 2'd1,
        ST_SHORT = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_WRITE
    } t_state;

endpackage

@@ src/dba_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dba_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/disk_block_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disk_block_allocator
// Linked file allocation over a block ownership map held in RAM.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the ownership map, one
// entry per cycle, with o_busy high; config writes are taken throughout.
// A request is taken when i_start is high and o_busy is low. A request that
// fails the range checks yields one error word in the cycle after accept; a
// taken start block is reported once the start entry has been read back.
// An accepted request reads the start entry, scans the map from block 0 one
// entry per cycle through the single map read port until enough free blocks
// are found (or ends with an error word once the configured blocks run out),
// then streams the chosen blocks back into the map, emitting one word per
// cycle. Words appear on o_strobe for a single cycle and must be taken.
// ----------------------------------------------------------------------------
module disk_block_allocator
    import dba_pkg::*;
#(
    parameter int BLOCK_COUNT = BLOCK_COUNT_DEF,
    parameter int MAX_FILES   = MAX_FILES_DEF,
    parameter int MAX_LENGTH  = MAX_LENGTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [BLK_IDX_W-1:0] i_start_block,
    input  logic [LEN_W-1:0]     i_length,
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_strobe,
    output logic [BLK_IDX_W-1:0] o_block_index,
    output logic [FID_W-1:0]     o_file_id,
    output logic [STAT_W-1:0]    o_status,
    output logic                 o_last
);

    localparam int AW = $clog2(BLOCK_COUNT);
    localparam int CW = AW + 1;
    localparam int FW = $clog2(MAX_FILES + 1);
    localparam int LW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

    t_state r_state, n_state;
    logic [CFG_W-1:0] r_cfg;
    logic [CW-1:0]    r_clr, n_clr;
    logic [FW-1:0]    r_files, n_files;
    logic             r_pend, n_pend;
    logic             r_wpend, n_wpend;
    logic             r_strobe, n_strobe;

    logic [AW-1:0]        r_start, n_start;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [FW-1:0]        r_id, n_id;
    logic [LEN_W-1:0]     r_found, n_found;
    logic [CW-1:0]        r_scan, n_scan;
    logic [AW-1:0]        r_paddr, n_paddr;
    logic [LEN_W-1:0]     r_k, n_k;
    logic [LEN_W-1:0]     r_wk, n_wk;
    logic [BLK_IDX_W-1:0] r_blk, n_blk;
    logic [FID_W-1:0]     r_fid, n_fid;
    t_status              r_status, n_status;
    logic                 r_last, n_last;

    logic [CW-1:0]    nblk;
    logic             bad;
    logic             hit;
    logic [LEN_W-1:0] found_nx;

    logic          map_we;
    logic [AW-1:0] map_waddr, map_raddr;
    logic [FW-1:0] map_wdata, map_rdata;
    logic          ch_we;
    logic [LW-1:0] ch_waddr, ch_raddr;
    logic [AW-1:0] ch_wdata, ch_rdata;

    dba_ram #(
        .WIDTH (FW),
        .DEPTH (BLOCK_COUNT)
    ) u_owner_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    dba_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_LENGTH)
    ) u_chosen (
        .i_clk   (i_clk),
        .i_we    (ch_we),
        .i_waddr (ch_waddr),
        .i_wdata (ch_wdata),
        .i_raddr (ch_raddr),
        .o_rdata (ch_rdata)
    );

    always_comb begin
        if (32'(r_cfg) >= 32'(BLOCK_COUNT)) begin
            nblk = CW'(BLOCK_COUNT);
        end else begin
            nblk = CW'(r_cfg);
        end
    end

    assign bad = (32'(i_start_block) >= 32'(nblk)) || (i_length == '0) ||
                 (32'(i_length) > 32'(MAX_LENGTH)) || (32'(r_files) >= 32'(MAX_FILES));

    assign hit      = r_pend && (map_rdata == '0) && (r_paddr != r_start);
    assign found_nx = r_found + LEN_W'(hit);

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_files  = r_files;
        n_pend   = r_pend;
        n_wpend  = r_wpend;
        n_start  = r_start;
        n_len    = r_len;
        n_id     = r_id;
        n_found  = r_found;
        n_scan   = r_scan;
        n_paddr  = r_paddr;
        n_k      = r_k;
        n_wk     = r_wk;
        n_strobe = 1'b0;
        n_blk    = '0;
        n_fid    = '0;
        n_status = ST_OK;
        n_last   = 1'b0;
        map_we    = 1'b0;
        map_waddr = '0;
        map_wdata = '0;
        map_raddr = '0;
        ch_we     = 1'b0;
        ch_waddr  = '0;
        ch_wdata  = '0;
        ch_raddr  = '0;

        unique case (r_state)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = r_clr[AW-1:0];
                if (r_clr == CW'(BLOCK_COUNT - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + CW'(1);
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_len   = i_length;
                    n_start = AW'(i_start_block);
                    if (bad) begin
                        n_strobe = 1'b1;
                        n_status = ST_BAD;
                        n_last   = 1'b1;
                    end else begin
                        map_raddr = AW'(i_start_block);
                        n_state   = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (map_rdata != '0) begin
                    n_strobe = 1'b1;
                    n_status = ST_TAKEN;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    ch_we    = 1'b1;
                    ch_wdata = r_start;
                    n_found  = LEN_W'(1);
                    n_scan   = '0;
                    n_pend   = 1'b0;
                    n_id     = r_files + FW'(1);
                    if (r_len == LEN_W'(1)) begin
                        n_files = r_files + FW'(1);
                        n_k     = '0;
                        n_wpend = 1'b0;
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    ch_we    = 1'b1;
                    ch_waddr = r_found[LW-1:0];
                    ch_wdata = r_paddr;
                end
                map_raddr = r_scan[AW-1:0];
                if (r_scan < nblk) begin
                    n_pend  = 1'b1;
                    n_paddr = r_scan[AW-1:0];
                    n_scan  = r_scan + CW'(1);
                end else begin
                    n_pend = 1'b0;
                end
                n_found = found_nx;
                if (found_nx == r_len) begin
                    n_files = r_id;
                    n_k     = '0;
                    n_wpend = 1'b0;
                    n_state = S_WRITE;
                end else if (!r_pend && (r_scan >= nblk)) begin
                    n_strobe = 1'b1;
                    n_status = ST_SHORT;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_WRITE: begin
                ch_raddr = r_k[LW-1:0];
                if (r_k < r_len) begin
                    n_wpend = 1'b1;
                    n_wk    = r_k;
                    n_k     = r_k + LEN_W'(1);
                end else begin
                    n_wpend = 1'b0;
                end
                if (r_wpend) begin
                    map_we    = 1'b1;
                    map_waddr = ch_rdata;
                    map_wdata = r_id;
                    n_strobe  = 1'b1;
                    n_blk     = BLK_IDX_W'(ch_rdata);
                    n_fid     = FID_W'(r_id);
                    n_status  = ST_OK;
                    n_last    = (r_wk == r_len - LEN_W'(1));
                    if (n_last) begin
                        n_wpend = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_cfg    <= CFG_RESET;
            r_files  <= '0;
            r_pend   <= 1'b0;
            r_wpend  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_files  <= n_files;
            r_pend   <= n_pend;
            r_wpend  <= n_wpend;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_start  <= n_start;
        r_len    <= n_len;
        r_id     <= n_id;
        r_found  <= n_found;
        r_scan   <= n_scan;
        r_paddr  <= n_paddr;
        r_k      <= n_k;
        r_wk     <= n_wk;
        r_blk    <= n_blk;
        r_fid    <= n_fid;
        r_status <= n_status;
        r_last   <= n_last;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_block_index = r_blk;
    assign o_file_id     = r_fid;
    assign o_status      = r_status;
    assign o_last        = r_last;

    a_ok_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_status == ST_OK)) |-> ($past(r_state) == S_WRITE))
        else $error("ok word outside write-back");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_status != ST_OK)) |-> r_last)
        else $error("error word not marked last");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_found < r_len))
        else $error("scan kept running past length");

    a_no_map_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) || (r_state == S_CHECK)) |-> !map_we)
        else $error("map written before allocation committed");

    a_files_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_files) <= 32'(MAX_FILES))
        else $error("file counter overflow");

endmodule
